FILE: rtl/rotor_initial_position_detect_assert.svh
// Assertion macros shared by the rotor position detector RTL
`ifndef ROTOR_INITIAL_POSITION_DETECT_ASSERT_SVH
`define ROTOR_INITIAL_POSITION_DETECT_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while in reset
`define RIPD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset
`define RIPD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ripd_pkg.sv
// Types, constants and sector tables for the rotor position detector
`timescale 1ns / 1ps
`default_nettype none

package ripd_pkg;

    localparam int SAMPLE_BITS_DEFAULT = 12;

    localparam int TOL_W        = 12;
    localparam int PULSE_W      = 16;
    localparam int GAIN_W       = 3;
    localparam int PAT_W        = 6;
    localparam int SECTOR_W     = 3;
    localparam int PHASE_CODE_W = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int M_DATA_W     = 32;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION    = 2'd0,
        CFG_TOLERANCE    = 2'd1,
        CFG_INIT_PULSE   = 2'd2,
        CFG_INIT_GAIN    = 2'd3
    } cfg_index_t;

    // input word kinds
    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic              DIRECTION_RESET = 1'b0;
    localparam logic [TOL_W-1:0]  TOLERANCE_RESET = 12'd20;
    localparam logic [PULSE_W-1:0] INIT_PULSE_RESET = 16'd100;
    localparam logic [GAIN_W-1:0] INIT_GAIN_RESET = 3'd3;

    // calibration window on the first sample
    localparam int CAL_LOW   = 100;
    localparam int CAL_HIGH  = 200;
    localparam int CAL_OVER  = 300;
    localparam int PULSE_STEP = 10;

    localparam logic [PULSE_W-1:0] PULSE_MAX = 16'hFFFF;
    localparam logic [GAIN_W-1:0]  GAIN_MAX  = 3'd7;
    localparam logic [GAIN_W-1:0]  GAIN_MIN  = 3'd0;

    localparam logic [PHASE_CODE_W-1:0] PHASE_U    = 3'b100;
    localparam logic [PHASE_CODE_W-1:0] PHASE_V    = 3'b010;
    localparam logic [PHASE_CODE_W-1:0] PHASE_W    = 3'b001;
    localparam logic [PHASE_CODE_W-1:0] PHASE_NONE = 3'b000;
    localparam logic [PHASE_CODE_W-1:0] PHASE_ALL  = 3'b111;

    // switch patterns, UH VH WH UL VL WL from bit 5 down
    localparam logic [PAT_W-1:0] PAT_NONE  = 6'h00;
    localparam logic [PAT_W-1:0] PAT_U_POS = 6'h23;
    localparam logic [PAT_W-1:0] PAT_U_NEG = 6'h1C;
    localparam logic [PAT_W-1:0] PAT_V_POS = 6'h15;
    localparam logic [PAT_W-1:0] PAT_V_NEG = 6'h2A;
    localparam logic [PAT_W-1:0] PAT_W_POS = 6'h0E;
    localparam logic [PAT_W-1:0] PAT_W_NEG = 6'h31;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_CAL  = 7'b0000010,
        ST_U2   = 7'b0000100,
        ST_V1   = 7'b0001000,
        ST_V2   = 7'b0010000,
        ST_W1   = 7'b0100000,
        ST_W2   = 7'b1000000
    } stage_t;

    // phase code to commutation sector; codes 0 and 7 give no sector
    function automatic logic [SECTOR_W-1:0] sector_lookup(input logic ccw,
                                                          input logic [PHASE_CODE_W-1:0] code);
        logic [SECTOR_W-1:0] sec;
        sec = 3'd0;
        case (code)
            3'd1:    sec = ccw ? 3'd2 : 3'd5;
            3'd2:    sec = ccw ? 3'd4 : 3'd3;
            3'd3:    sec = ccw ? 3'd3 : 3'd4;
            3'd4:    sec = ccw ? 3'd6 : 3'd1;
            3'd5:    sec = ccw ? 3'd1 : 3'd6;
            3'd6:    sec = ccw ? 3'd5 : 3'd2;
            default: sec = 3'd0;
        endcase
        return sec;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rotor_initial_position_detect.sv
// Six-pulse inductive saliency sequencer that finds the initial rotor sector
//
// Channels: the s_axis input takes one word per handshake; tuser is the kind
// (0 start a detection, 1 current sample) and tdata holds the sample. Each
// input word yields exactly one m_axis result word: the next drive pattern,
// pulse length and gain, with tlast set on the word that ends a detection and
// carries the sector and the forced-alignment flag. The cfg channel writes
// direction, tolerance, initial pulse time and initial gain by index; it is
// always ready, and the user must write it only while the block is idle,
// which the block itself does not enforce. A word passes the input register,
// then the result register. Throughput is one word per cycle while
// m_axis_tready is high; the sequencer state is updated in the single
// combinational pass between the two registers, which is what sets the cycle.
// Reset (aresetn low, synchronous) empties both registers, returns the
// sequencer to idle and loads the configuration reset values.
// When the receiver stalls the result word holds, one more word is taken into
// the input register, and s_axis_tready then drops until m_axis_tready rises.
`timescale 1ns / 1ps
`default_nettype none

`include "rotor_initial_position_detect_assert.svh"

module rotor_initial_position_detect #(
    parameter int SAMPLE_BITS = ripd_pkg::SAMPLE_BITS_DEFAULT,
    localparam int S_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    // configuration write channel
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [ripd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [ripd_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input words
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [S_DATA_W-1:0]                s_axis_tdata,  // sample
    input  wire                                s_axis_tuser,  // op
    // result words
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // drive_pattern, pulse_time, gain, sector, force_align, zero fill
    output logic [ripd_pkg::M_DATA_W-1:0]      m_axis_tdata,
    output logic                               m_axis_tlast   // done_res
);

    localparam int CMP_W = ((SAMPLE_BITS > ripd_pkg::TOL_W) ? SAMPLE_BITS
                                                            : ripd_pkg::TOL_W) + 1;
    localparam int PAD_W = ripd_pkg::M_DATA_W - ripd_pkg::PAT_W - ripd_pkg::PULSE_W
                         - ripd_pkg::GAIN_W - ripd_pkg::SECTOR_W - 1;

    // configuration
    logic                              direction_reg;
    logic [ripd_pkg::TOL_W-1:0]        tolerance_reg;
    logic [ripd_pkg::PULSE_W-1:0]      init_pulse_reg;
    logic [ripd_pkg::GAIN_W-1:0]       init_gain_reg;

    // input register
    logic                              in_valid_reg;
    logic                              in_op_reg;
    logic [SAMPLE_BITS-1:0]            in_sample_reg;

    // sequencer state
    ripd_pkg::stage_t                  stage_reg, stage_next;
    logic [ripd_pkg::GAIN_W-1:0]       gain_now_reg, gain_now_next;
    logic [ripd_pkg::PULSE_W-1:0]      pulse_now_reg, pulse_now_next;
    logic [SAMPLE_BITS-1:0]            first_sample_reg, first_sample_next;
    logic [ripd_pkg::PHASE_CODE_W-1:0] phase_code_reg, phase_code_next;

    // result register
    logic                              out_valid_reg;
    logic [ripd_pkg::PAT_W-1:0]        pat_reg, pat_next;
    logic [ripd_pkg::PULSE_W-1:0]      pulse_out_reg;
    logic [ripd_pkg::GAIN_W-1:0]       gain_out_reg;
    logic                              done_reg, done_next;
    logic [ripd_pkg::SECTOR_W-1:0]     sector_reg, sector_next;
    logic                              force_reg, force_next;

    logic                              advance;
    logic [CMP_W-1:0]                  s_ext;
    logic [CMP_W-1:0]                  first_ext;
    logic [CMP_W-1:0]                  tol_ext;
    logic [CMP_W-1:0]                  diff;
    logic                              salient;
    logic [ripd_pkg::PULSE_W:0]        pulse_sum;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg  <= ripd_pkg::DIRECTION_RESET;
            tolerance_reg  <= ripd_pkg::TOLERANCE_RESET;
            init_pulse_reg <= ripd_pkg::INIT_PULSE_RESET;
            init_gain_reg  <= ripd_pkg::INIT_GAIN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ripd_pkg::CFG_DIRECTION:  direction_reg  <= cfg_data[0];
                ripd_pkg::CFG_TOLERANCE:  tolerance_reg  <= cfg_data[ripd_pkg::TOL_W-1:0];
                ripd_pkg::CFG_INIT_PULSE: init_pulse_reg <= cfg_data[ripd_pkg::PULSE_W-1:0];
                ripd_pkg::CFG_INIT_GAIN:  init_gain_reg  <= cfg_data[ripd_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // input register: take a word whenever the slot is free or draining
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_op_reg     <= s_axis_tuser;
            in_sample_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
    end

    assign s_ext     = CMP_W'(in_sample_reg);
    assign first_ext = CMP_W'(first_sample_reg);
    assign tol_ext   = CMP_W'(tolerance_reg);
    assign diff      = s_ext - first_ext;
    assign salient   = (s_ext > first_ext) && (diff > tol_ext);
    assign pulse_sum = {1'b0, pulse_now_reg} + (ripd_pkg::PULSE_W+1)'(ripd_pkg::PULSE_STEP);

    always_comb begin
        stage_next        = stage_reg;
        gain_now_next     = gain_now_reg;
        pulse_now_next    = pulse_now_reg;
        first_sample_next = first_sample_reg;
        phase_code_next   = phase_code_reg;
        pat_next          = ripd_pkg::PAT_NONE;
        done_next         = 1'b0;
        sector_next       = '0;
        force_next        = 1'b0;

        if (in_op_reg == ripd_pkg::OP_START) begin
            stage_next        = ripd_pkg::ST_CAL;
            gain_now_next     = init_gain_reg;
            pulse_now_next    = init_pulse_reg;
            first_sample_next = '0;
            phase_code_next   = ripd_pkg::PHASE_NONE;
            pat_next          = ripd_pkg::PAT_U_POS;
        end else begin
            case (stage_reg)
                ripd_pkg::ST_CAL: begin
                    if (s_ext < CMP_W'(ripd_pkg::CAL_LOW)) begin
                        if (gain_now_reg != ripd_pkg::GAIN_MIN) begin
                            gain_now_next = gain_now_reg - 3'd1;
                        end
                    end else if (s_ext > CMP_W'(ripd_pkg::CAL_OVER)) begin
                        if (gain_now_reg != ripd_pkg::GAIN_MAX) begin
                            gain_now_next = gain_now_reg + 3'd1;
                        end
                    end else if (s_ext > CMP_W'(ripd_pkg::CAL_HIGH) &&
                                 s_ext < CMP_W'(ripd_pkg::CAL_OVER)) begin
                        // lengthen the pulse, saturating at full scale
                        pulse_now_next = pulse_sum[ripd_pkg::PULSE_W] ? ripd_pkg::PULSE_MAX
                                       : pulse_sum[ripd_pkg::PULSE_W-1:0];
                    end
                    if (s_ext >= CMP_W'(ripd_pkg::CAL_LOW) &&
                        s_ext <= CMP_W'(ripd_pkg::CAL_HIGH)) begin
                        first_sample_next = in_sample_reg;
                        stage_next        = ripd_pkg::ST_U2;
                        pat_next          = ripd_pkg::PAT_U_NEG;
                    end else begin
                        pat_next = ripd_pkg::PAT_U_POS;
                    end
                end
                ripd_pkg::ST_U2: begin
                    if (salient) phase_code_next = phase_code_reg | ripd_pkg::PHASE_U;
                    stage_next = ripd_pkg::ST_V1;
                    pat_next   = ripd_pkg::PAT_V_POS;
                end
                ripd_pkg::ST_V1: begin
                    first_sample_next = in_sample_reg;
                    stage_next        = ripd_pkg::ST_V2;
                    pat_next          = ripd_pkg::PAT_V_NEG;
                end
                ripd_pkg::ST_V2: begin
                    if (salient) phase_code_next = phase_code_reg | ripd_pkg::PHASE_V;
                    stage_next = ripd_pkg::ST_W1;
                    pat_next   = ripd_pkg::PAT_W_POS;
                end
                ripd_pkg::ST_W1: begin
                    first_sample_next = in_sample_reg;
                    stage_next        = ripd_pkg::ST_W2;
                    pat_next          = ripd_pkg::PAT_W_NEG;
                end
                ripd_pkg::ST_W2: begin
                    if (salient) phase_code_next = phase_code_reg | ripd_pkg::PHASE_W;
                    sector_next = ripd_pkg::sector_lookup(direction_reg, phase_code_next);
                    force_next  = (phase_code_next == ripd_pkg::PHASE_NONE) ||
                                  (phase_code_next == ripd_pkg::PHASE_ALL);
                    done_next   = 1'b1;
                    stage_next  = ripd_pkg::ST_IDLE;
                end
                default: begin
                    // sample while idle: drop it, report no pulse
                    stage_next = ripd_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // sequencer state advances with each word that moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg        <= ripd_pkg::ST_IDLE;
            gain_now_reg     <= ripd_pkg::INIT_GAIN_RESET;
            pulse_now_reg    <= ripd_pkg::INIT_PULSE_RESET;
            first_sample_reg <= '0;
            phase_code_reg   <= ripd_pkg::PHASE_NONE;
        end else if (advance) begin
            stage_reg        <= stage_next;
            gain_now_reg     <= gain_now_next;
            pulse_now_reg    <= pulse_now_next;
            first_sample_reg <= first_sample_next;
            phase_code_reg   <= phase_code_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            pat_reg       <= pat_next;
            pulse_out_reg <= pulse_now_next;
            gain_out_reg  <= gain_now_next;
            done_reg      <= done_next;
            sector_reg    <= sector_next;
            force_reg     <= force_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = done_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, force_reg, sector_reg, gain_out_reg,
                            pulse_out_reg, pat_reg};

    `RIPD_ASSERT_IMP(a_last_no_pulse, m_axis_tvalid && m_axis_tlast,
        pat_reg == ripd_pkg::PAT_NONE, "final word requests a drive pattern")
    `RIPD_ASSERT_NXT(a_done_to_idle, advance && done_next,
        stage_reg == ripd_pkg::ST_IDLE, "sequencer not idle after completion")
    `RIPD_ASSERT_IMP(a_force_no_sector, m_axis_tvalid && force_reg,
        m_axis_tlast && sector_reg == '0, "forced alignment with a sector")
    `RIPD_ASSERT_NXT(a_start_clears, advance && in_op_reg == ripd_pkg::OP_START,
        stage_reg == ripd_pkg::ST_CAL && phase_code_reg == ripd_pkg::PHASE_NONE,
        "start did not restart calibration")

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for the rotor initial position detector
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD = 300;

    // phase bits of the saliency code
    localparam logic [2:0] BIT_U = 3'b100;
    localparam logic [2:0] BIT_V = 3'b010;
    localparam logic [2:0] BIT_W = 3'b001;
    localparam logic [2:0] SECTOR_CW  [8] = '{3'd0, 3'd5, 3'd3, 3'd4, 3'd1, 3'd6, 3'd2, 3'd0};
    localparam logic [2:0] SECTOR_CCW [8] = '{3'd0, 3'd2, 3'd4, 3'd3, 3'd6, 3'd1, 3'd5, 3'd0};

    typedef struct packed {
        logic        op;
        logic [11:0] sample;
    } word_t;

    typedef struct packed {
        logic [5:0]  pattern;
        logic [15:0] pulse;
        logic [2:0]  gain;
        logic        done;
        logic [2:0]  sector;
        logic        align;
    } result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    rotor_initial_position_detect dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 aclk = ~aclk;

    // predictor copy of the registers and sequencer state
    logic        dir_reg = ripd_pkg::DIRECTION_RESET;
    logic [11:0] tol_reg = ripd_pkg::TOLERANCE_RESET;
    logic [15:0] init_pulse_reg = ripd_pkg::INIT_PULSE_RESET;
    logic [2:0]  init_gain_reg = ripd_pkg::INIT_GAIN_RESET;
    ripd_pkg::stage_t stage = ripd_pkg::ST_IDLE;
    logic [2:0]  gain_now = ripd_pkg::INIT_GAIN_RESET;
    logic [15:0] pulse_now = ripd_pkg::INIT_PULSE_RESET;
    logic [11:0] first_sample = '0;
    logic [2:0]  phase_code = '0;

    word_t   pending_words[$];
    result_t expected_results[$];

    int  idle_pct = 0;
    int  phase_no = 0;
    int  n_bad = 0;
    int  n_in = 0;
    int  n_out = 0;
    int  n_detect = 0;
    int  n_align = 0;
    logic [7:0] sectors_seen = '0;
    logic s_took = 1'b0;

    function automatic logic saliency(logic [11:0] first, logic [11:0] second);
        return second > first && (second - first) > tol_reg;
    endfunction

    // advance the sequencer by one word and return the result it yields
    function automatic result_t detect_step(word_t w);
        result_t r;
        r = '0;
        r.pattern = ripd_pkg::PAT_NONE;
        if (w.op == ripd_pkg::OP_START) begin
            stage = ripd_pkg::ST_CAL;
            gain_now = init_gain_reg;
            pulse_now = init_pulse_reg;
            first_sample = '0;
            phase_code = '0;
            r.pattern = ripd_pkg::PAT_U_POS;
        end else begin
            case (stage)
                ripd_pkg::ST_CAL: begin
                    if (w.sample < ripd_pkg::CAL_LOW) begin
                        if (gain_now > ripd_pkg::GAIN_MIN) gain_now = gain_now - 3'd1;
                    end else if (w.sample > ripd_pkg::CAL_OVER) begin
                        if (gain_now < ripd_pkg::GAIN_MAX) gain_now = gain_now + 3'd1;
                    end else if (w.sample > ripd_pkg::CAL_HIGH &&
                                 w.sample < ripd_pkg::CAL_OVER) begin
                        if (pulse_now > ripd_pkg::PULSE_MAX - ripd_pkg::PULSE_STEP)
                            pulse_now = ripd_pkg::PULSE_MAX;
                        else
                            pulse_now = 16'(pulse_now + ripd_pkg::PULSE_STEP);
                    end
                    if (w.sample >= ripd_pkg::CAL_LOW && w.sample <= ripd_pkg::CAL_HIGH) begin
                        first_sample = w.sample;
                        stage = ripd_pkg::ST_U2;
                        r.pattern = ripd_pkg::PAT_U_NEG;
                    end else begin
                        r.pattern = ripd_pkg::PAT_U_POS;
                    end
                end
                ripd_pkg::ST_U2: begin
                    if (saliency(first_sample, w.sample)) phase_code |= BIT_U;
                    stage = ripd_pkg::ST_V1;
                    r.pattern = ripd_pkg::PAT_V_POS;
                end
                ripd_pkg::ST_V1: begin
                    first_sample = w.sample;
                    stage = ripd_pkg::ST_V2;
                    r.pattern = ripd_pkg::PAT_V_NEG;
                end
                ripd_pkg::ST_V2: begin
                    if (saliency(first_sample, w.sample)) phase_code |= BIT_V;
                    stage = ripd_pkg::ST_W1;
                    r.pattern = ripd_pkg::PAT_W_POS;
                end
                ripd_pkg::ST_W1: begin
                    first_sample = w.sample;
                    stage = ripd_pkg::ST_W2;
                    r.pattern = ripd_pkg::PAT_W_NEG;
                end
                ripd_pkg::ST_W2: begin
                    if (saliency(first_sample, w.sample)) phase_code |= BIT_W;
                    r.sector = dir_reg ? SECTOR_CCW[phase_code] : SECTOR_CW[phase_code];
                    r.align = (phase_code == ripd_pkg::PHASE_NONE ||
                               phase_code == ripd_pkg::PHASE_ALL);
                    r.done = 1'b1;
                    stage = ripd_pkg::ST_IDLE;
                end
                default: stage = ripd_pkg::ST_IDLE;
            endcase
        end
        r.pulse = pulse_now;
        r.gain = gain_now;
        return r;
    endfunction

    // check results, predict from accepted words, track register writes
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        s_took <= aresetn && s_axis_tvalid && s_axis_tready;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.pattern = m_axis_tdata[5:0];
                got.pulse   = m_axis_tdata[21:6];
                got.gain    = m_axis_tdata[24:22];
                got.sector  = m_axis_tdata[27:25];
                got.align   = m_axis_tdata[28];
                got.done    = m_axis_tlast;
                n_out++;
                if (expected_results.size() == 0) begin
                    n_bad++;
                    $display("%0t: result word with none expected: pattern %h pulse %0d",
                             $realtime, got.pattern, got.pulse);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        n_bad++;
                        $display({"%0t: mismatch expected pat %h pulse %0d gain %0d",
                                  " done %b sector %0d align %b"},
                                 $realtime, want.pattern, want.pulse, want.gain, want.done,
                                 want.sector, want.align);
                        $display({"%0t:          actual   pat %h pulse %0d gain %0d",
                                  " done %b sector %0d align %b"},
                                 $realtime, got.pattern, got.pulse, got.gain, got.done,
                                 got.sector, got.align);
                    end
                    if (want.done) begin
                        n_detect++;
                        if (want.align) n_align++;
                        sectors_seen[want.sector] = 1'b1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(detect_step('{op: s_axis_tuser,
                                                         sample: s_axis_tdata[11:0]}));
                n_in++;
            end
            if (cfg_valid && cfg_ready) begin
                case (ripd_pkg::cfg_index_t'(cfg_index))
                    ripd_pkg::CFG_DIRECTION:  dir_reg = cfg_data[0];
                    ripd_pkg::CFG_TOLERANCE:  tol_reg = cfg_data[11:0];
                    ripd_pkg::CFG_INIT_PULSE: init_pulse_reg = cfg_data;
                    ripd_pkg::CFG_INIT_GAIN:  init_gain_reg = cfg_data[2:0];
                    default: ;
                endcase
            end
        end
    end

    // input driver: next word once the current one is taken, with idle bursts
    int s_gap = 0;
    always @(negedge aclk) begin
        word_t w;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_took) begin
            if (s_gap > 0) begin
                s_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (idle_pct > 0 && pending_words.size() > 0
                         && $urandom_range(0, 99) < idle_pct) begin
                s_gap = $urandom_range(0, 10);
                s_axis_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                w = pending_words.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {4'b0, w.sample};
                s_axis_tuser <= w.op;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls, and one long hold-off to fill the block
    int  m_gap = 0;
    int  hold_left = 0;
    logic hold_done = 1'b0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && phase_no == 4 && s_axis_tvalid) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (m_gap > 0) begin
            m_gap--;
            m_axis_tready <= 1'b0;
        end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            m_gap = $urandom_range(0, 10);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // end the run if no word moves on any channel for too long
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $realtime, WATCHDOG_LIMIT, expected_results.size());
            $display("rotor_initial_position_detect test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic put(logic op, logic [11:0] s);
        pending_words.push_back('{op: op, sample: s});
    endtask

    // hold until every word has gone through and the block has settled
    task automatic settle();
        while (pending_words.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(ripd_pkg::cfg_index_t idx, logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic configure(logic d, logic [11:0] t, logic [15:0] p, logic [2:0] g);
        write_reg(ripd_pkg::CFG_DIRECTION, {15'b0, d});
        write_reg(ripd_pkg::CFG_TOLERANCE, {4'b0, t});
        write_reg(ripd_pkg::CFG_INIT_PULSE, p);
        write_reg(ripd_pkg::CFG_INIT_GAIN, {13'b0, g});
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // calibration sample that keeps the first pulse repeating
    function automatic logic [11:0] miss_sample();
        case ($urandom_range(0, 3))
            0: return 12'($urandom_range(0, ripd_pkg::CAL_LOW - 1));
            1: return 12'($urandom_range(ripd_pkg::CAL_OVER + 1, 4095));
            2: return 12'($urandom_range(ripd_pkg::CAL_HIGH + 1, ripd_pkg::CAL_OVER - 1));
            default: return 12'(ripd_pkg::CAL_OVER);
        endcase
    endfunction

    // second sample of a pair, clustered around the tolerance edge
    function automatic logic [11:0] pair_second(logic [11:0] first);
        int v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 4095);
            1: v = int'(first) + int'(tol_reg) + $urandom_range(0, 2);
            2: v = int'(first) - $urandom_range(0, 40);
            default: v = int'(first) + $urandom_range(0, 2 * int'(tol_reg) + 2);
        endcase
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return 12'(v);
    endfunction

    task automatic add_random(int n);
        int count;
        int r;
        int k;
        logic [11:0] a;
        count = 0;
        while (count < n) begin
            r = $urandom_range(0, 99);
            if (r < 85) begin
                // full detection, cut short now and then
                k = (r < 75) ? 9 : $urandom_range(1, 5);
                put(ripd_pkg::OP_START, 12'($urandom));
                count++;
                repeat ($urandom_range(0, 4)) begin
                    put(ripd_pkg::OP_SAMPLE, miss_sample());
                    count++;
                end
                a = 12'($urandom_range(ripd_pkg::CAL_LOW, ripd_pkg::CAL_HIGH));
                put(ripd_pkg::OP_SAMPLE, a);
                put(ripd_pkg::OP_SAMPLE, pair_second(a));
                count += 2;
                if (k > 2) begin
                    a = 12'($urandom);
                    put(ripd_pkg::OP_SAMPLE, a);
                    put(ripd_pkg::OP_SAMPLE, pair_second(a));
                    count += 2;
                end
                if (k > 4) begin
                    a = 12'($urandom);
                    put(ripd_pkg::OP_SAMPLE, a);
                    put(ripd_pkg::OP_SAMPLE, pair_second(a));
                    count += 2;
                end
            end else if (r < 95) begin
                put(ripd_pkg::OP_SAMPLE, 12'($urandom));
            end else begin
                put(1'($urandom), 12'($urandom));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset register values, walk the calibration rules and both outcomes
        phase_no = 1;
        idle_pct = 20;
        put(ripd_pkg::OP_SAMPLE, 12'hFFF);
        put(ripd_pkg::OP_START, 12'hABC);
        put(ripd_pkg::OP_SAMPLE, 12'd0);   put(ripd_pkg::OP_SAMPLE, 12'd4095);
        put(ripd_pkg::OP_SAMPLE, 12'd300); put(ripd_pkg::OP_SAMPLE, 12'd250);
        put(ripd_pkg::OP_SAMPLE, 12'd99);  put(ripd_pkg::OP_SAMPLE, 12'd301);
        put(ripd_pkg::OP_SAMPLE, 12'd201); put(ripd_pkg::OP_SAMPLE, 12'd299);
        put(ripd_pkg::OP_SAMPLE, 12'd100); put(ripd_pkg::OP_SAMPLE, 12'd121);
        put(ripd_pkg::OP_SAMPLE, 12'd4095); put(ripd_pkg::OP_SAMPLE, 12'd0);
        put(ripd_pkg::OP_SAMPLE, 12'd0);   put(ripd_pkg::OP_SAMPLE, 12'd4095);
        put(ripd_pkg::OP_SAMPLE, 12'h555);
        put(ripd_pkg::OP_START, 12'd0);    put(ripd_pkg::OP_START, 12'h0FF);
        put(ripd_pkg::OP_SAMPLE, 12'd200); put(ripd_pkg::OP_SAMPLE, 12'd220);
        put(ripd_pkg::OP_SAMPLE, 12'd50);  put(ripd_pkg::OP_SAMPLE, 12'd50);
        put(ripd_pkg::OP_SAMPLE, 12'd10);  put(ripd_pkg::OP_SAMPLE, 12'd10);
        add_random(250);
        settle();

        // pulse and gain at the top, zero tolerance, all phases salient
        phase_no = 2;
        configure(1'b1, 12'd0, 16'd65530, 3'd7);
        idle_pct = 0;
        put(ripd_pkg::OP_START, 12'd0);
        put(ripd_pkg::OP_SAMPLE, 12'd250); put(ripd_pkg::OP_SAMPLE, 12'd250);
        put(ripd_pkg::OP_SAMPLE, 12'd4095); put(ripd_pkg::OP_SAMPLE, 12'd150);
        put(ripd_pkg::OP_SAMPLE, 12'd151); put(ripd_pkg::OP_SAMPLE, 12'd0);
        put(ripd_pkg::OP_SAMPLE, 12'd1);   put(ripd_pkg::OP_SAMPLE, 12'd100);
        put(ripd_pkg::OP_SAMPLE, 12'd4095);
        add_random(250);
        settle();

        phase_no = 3;
        configure(1'b0, 12'd4095, 16'd0, 3'd0);
        idle_pct = 25;
        add_random(250);
        settle();

        // the receiver holds off for a long stretch during this one
        phase_no = 4;
        configure(1'b1, 12'd20, 16'd100, 3'd3);
        idle_pct = 20;
        add_random(300);
        settle();

        phase_no = 5;
        configure(1'($urandom), 12'($urandom_range(0, 60)), 16'($urandom),
                  3'($urandom_range(0, 7)));
        idle_pct = 15;
        add_random(250);
        settle();

        // closing stretch without idling
        phase_no = 6;
        configure(1'b0, 12'd1, 16'd65525, 3'd5);
        idle_pct = 0;
        add_random(300);
        settle();
        repeat (10) @(negedge aclk);

        $display("Run covered %0d input words and %0d results over six register settings.",
                 n_in, n_out);
        $display("Detections finished: %0d, forced alignment: %0d, sector codes seen: %b.",
                 n_detect, n_align, sectors_seen);
        if (n_bad == 0 && expected_results.size() == 0) begin
            $display("rotor_initial_position_detect test passed");
        end else begin
            $display("%0d mismatches, %0d results never arrived", n_bad,
                     expected_results.size());
            $display("rotor_initial_position_detect test failed");
        end
        $finish;
    end

endmodule

FILE: rotor_initial_position_detect.f
+incdir+rtl
rtl/ripd_pkg.sv
rtl/rotor_initial_position_detect.sv
sim/tb.sv
